@@ hdl/olst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olst_pkg
// Shared codes for the ordered list store: actions, status codes and the
// command that drives the row of storage cells.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_GET    = 2'd1,
        ACT_SET    = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // Command broadcast to every cell in the row
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2
    } cell_op_t;

endpackage : olst_pkg
`default_nettype wire

@@ hdl/olst_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// olst_cell
// One entry of the list. Loads the broadcast word when the position matches
// its own index, or takes its right neighbor's word on a shift at or above
// the position.
// ----------------------------------------------------------------------------
module olst_cell
    import olst_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int IDX_W     = 6,
    parameter int INDEX     = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_op_t             op,
    input  wire logic [IDX_W-1:0]     pos,
    input  wire logic [WORD_BITS-1:0] word_load,
    input  wire logic [WORD_BITS-1:0] word_right,
    output logic      [WORD_BITS-1:0] word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (op)
            CELL_LOAD:
            begin
                if (pos == MY_IDX)
                begin
                    word_next = word_load;
                end
            end
            CELL_SHIFT:
            begin
                // cells past the count hold zero, so shifting them in clears the tail
                if (MY_IDX >= pos)
                begin
                    word_next = word_right;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule : olst_cell
`default_nettype wire

@@ hdl/ordered_list_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store
// Fixed-depth ordered list held in a row of cells, with append, get, set and
// shift-down remove.
// ----------------------------------------------------------------------------
// Results are registered. Throughput: one item per cycle unless a result
// beat waits on out_ready; the whole row of cells updates in the accept
// cycle, and the output register frees as soon as its beat is taken.
// Reset clears every entry and the count; the block is ready right after.
// ----------------------------------------------------------------------------
module ordered_list_store
    import olst_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [SLOT_W-1:0]   slot,
    input  wire logic [WORD_W-1:0]   word_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [STATUS_W-1:0] status,
    output logic      [WORD_W-1:0]   word_out,
    output logic      [USED_W-1:0]   used
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [WORD_W-1:0]    word_out_reg;
    logic [USED_W-1:0]    used_reg;

    logic                 accept;
    action_t              act;
    logic [WORD_BITS-1:0] word_m;
    logic [CMP_W-1:0]     slot_c;
    logic [CMP_W-1:0]     count_c;
    logic                 slot_in_depth;
    logic                 slot_lt_count;
    logic                 is_full;
    status_t              status_new;
    logic [WORD_BITS-1:0] rd_word;
    cell_op_t             cell_op;
    logic [IDX_W-1:0]     cell_pos;

    logic [WORD_BITS-1:0] cell_word [0:DEPTH];

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign act      = action_t'(action);
    assign word_m   = WORD_BITS'({{WORD_BITS{1'b0}}, word_in});
    assign slot_c   = CMP_W'(slot);
    assign count_c  = CMP_W'(count_reg);

    assign slot_in_depth = slot_c < CMP_W'(DEPTH);
    assign slot_lt_count = slot_c < count_c;
    assign is_full       = count_reg == CNT_W'(DEPTH);

    // AND-OR read of the addressed cell
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_c == CMP_W'(i))
            begin
                rd_word = rd_word | cell_word[i];
            end
        end
    end

    always_comb
    begin
        status_new = ST_OK;
        count_next = count_reg;
        cell_op    = CELL_HOLD;
        cell_pos   = IDX_W'(slot_c);
        case (act)
            ACT_APPEND:
            begin
                cell_pos = IDX_W'(count_reg);
                if (word_m == '0)
                begin
                    status_new = ST_ZERO;
                end
                else if (is_full)
                begin
                    status_new = ST_FULL;
                end
                else
                begin
                    cell_op    = CELL_LOAD;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_GET:
            begin
                if (!slot_lt_count)
                begin
                    status_new = ST_RANGE;
                end
            end
            ACT_SET:
            begin
                if (!slot_in_depth)
                begin
                    status_new = ST_RANGE;
                end
                else
                begin
                    cell_op = CELL_LOAD;
                    if (!slot_lt_count)
                    begin
                        count_next = CNT_W'(slot_c + 1'b1);
                    end
                end
            end
            ACT_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status_new = ST_EMPTY;
                end
                else if (!slot_lt_count)
                begin
                    status_new = ST_RANGE;
                end
                else
                begin
                    cell_op    = CELL_SHIFT;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_new = ST_OK;
            end
        endcase
    end

    // Row of cells; the last one shifts in zero
    assign cell_word[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        olst_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX_W     (IDX_W),
            .INDEX     (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (accept ? cell_op : CELL_HOLD),
            .pos        (cell_pos),
            .word_load  (word_m),
            .word_right (cell_word[g + 1]),
            .word       (cell_word[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until the next accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_new;
            used_reg   <= USED_W'({{USED_W{1'b0}}, count_next});
            if (act == ACT_GET && slot_lt_count)
            begin
                word_out_reg <= WORD_W'({{WORD_W{1'b0}}, rd_word});
            end
            else
            begin
                word_out_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign word_out  = word_out_reg;
    assign used      = used_reg;

endmodule : ordered_list_store
`default_nettype wire
